@@ hdl/rcbd_pkg.sv @@
`timescale 1ns / 1ps

package rcbd_pkg;

  localparam int DataW        = 64;
  localparam int KeyW         = 32;
  localparam int CfgIdxW      = 3;
  localparam int BlockBitsDef = 64;
  localparam int CntW         = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRIME_P = 3'd0,
    CFG_PRIME_Q = 3'd1,
    CFG_EXP_P   = 3'd2,
    CFG_EXP_Q   = 3'd3,
    CFG_Q_INV   = 3'd4,
    CFG_MODULUS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [KeyW-1:0]  prime_p;
    logic [KeyW-1:0]  prime_q;
    logic [KeyW-1:0]  exp_p;
    logic [KeyW-1:0]  exp_q;
    logic [KeyW-1:0]  q_inv;
    logic [DataW-1:0] modulus;
  } key_t;

  typedef enum logic {
    OP_MUL,
    OP_REM
  } arith_op_e;

  typedef enum logic [2:0] {
    SRC_C,
    SRC_ACC,
    SRC_BAS,
    SRC_T,
    SRC_U,
    SRC_Q,
    SRC_IQ,
    SRC_SUM
  } src_e;

  typedef enum logic [1:0] {
    MOD_P,
    MOD_Q,
    MOD_N
  } mod_e;

  typedef enum logic [1:0] {
    DST_ACC,
    DST_BAS,
    DST_T,
    DST_U
  } dst_e;

  typedef enum logic [1:0] {
    AU_IDLE,
    AU_MUL,
    AU_REM
  } au_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PH_INIT,
    ST_BASE_W,
    ST_EXP_CHK,
    ST_AMUL_W,
    ST_ARED_S,
    ST_ARED_W,
    ST_BSQ_S,
    ST_BMUL_W,
    ST_BRED_S,
    ST_BRED_W,
    ST_QMOD_S,
    ST_QMOD_W,
    ST_DIFF,
    ST_HRD_S,
    ST_HRD_W,
    ST_HIQ_S,
    ST_HIQ_W,
    ST_HMUL_S,
    ST_HMUL_W,
    ST_HRED_S,
    ST_HRED_W,
    ST_RQ_S,
    ST_RQ_W,
    ST_FIN_S,
    ST_FIN_W,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic      load_in;
    logic      start;
    arith_op_e op;
    src_e      src_a;
    src_e      src_b;
    mod_e      mod_sel;
    logic      wr_res;
    dst_e      dst;
    logic      init_exp;
    logic      sel_q;
    logic      shift_exp;
    logic      save_m;
    logic      save_diff;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic arith_done;
    logic arith_busy;
    logic exp_zero;
    logic exp_bit0;
    logic exp_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/rcbd_cipher_if.sv @@
`timescale 1ns / 1ps

interface rcbd_cipher_if;
  logic                       valid;
  logic                       ready;
  logic [rcbd_pkg::DataW-1:0] cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink (input valid, input cipher_block, output ready);
endinterface

@@ hdl/rcbd_plain_if.sv @@
`timescale 1ns / 1ps

interface rcbd_plain_if;
  logic                       valid;
  logic                       ready;
  logic [rcbd_pkg::DataW-1:0] plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink (input valid, input plain_block, output ready);
endinterface

@@ hdl/rcbd_arith.sv @@
`timescale 1ns / 1ps

module rcbd_arith (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  rcbd_pkg::arith_op_e        op_i,
  input  logic [rcbd_pkg::DataW-1:0] a_i,
  input  logic [rcbd_pkg::DataW-1:0] b_i,
  input  logic [rcbd_pkg::DataW-1:0] d_i,
  output logic [rcbd_pkg::DataW-1:0] res_o,
  output logic                       done_o,
  output logic                       busy_o
);
  import rcbd_pkg::*;

  localparam int HalfW = DataW / 2;

  au_state_e             mode_q, mode_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DataW-1:0]      a_q, b_q, d_q, res_q;
  logic [HalfW-1:0]      mx, my;
  logic [DataW-1:0]      prod;
  logic [DataW:0]        sh, sub;
  logic                  ge;

  // low 64 bits of a*b from three 32x32 partial products
  assign mx   = (cnt_q == CntW'(2)) ? a_q[DataW-1:HalfW] : a_q[HalfW-1:0];
  assign my   = (cnt_q == CntW'(1)) ? b_q[DataW-1:HalfW] : b_q[HalfW-1:0];
  assign prod = {{HalfW{1'b0}}, mx} * {{HalfW{1'b0}}, my};

  // restoring remainder, one dividend bit a cycle
  assign sh  = {res_q, a_q[DataW-1]};
  assign sub = sh - {1'b0, d_q};
  assign ge  = (sh >= {1'b0, d_q});

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    unique case (mode_q)
      AU_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          if (op_i == OP_MUL) begin
            mode_d = AU_MUL;
          end else if (d_i == '0) begin
            done_d = 1'b1;
          end else begin
            mode_d = AU_REM;
          end
        end
      end
      AU_MUL: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(2)) begin
          mode_d = AU_IDLE;
          done_d = 1'b1;
        end
      end
      AU_REM: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DataW - 1)) begin
          mode_d = AU_IDLE;
          done_d = 1'b1;
        end
      end
      default: mode_d = AU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= AU_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (mode_q)
      AU_IDLE: begin
        if (start_i) begin
          a_q   <= a_i;
          b_q   <= b_i;
          d_q   <= d_i;
          // a zero divisor stands for 2^64: the value passes unchanged
          res_q <= (op_i == OP_REM && d_i == '0) ? a_i : '0;
        end
      end
      AU_MUL: begin
        if (cnt_q == '0) begin
          res_q <= prod;
        end else begin
          res_q[DataW-1:HalfW] <= res_q[DataW-1:HalfW] + prod[HalfW-1:0];
        end
      end
      AU_REM: begin
        res_q <= ge ? sub[DataW-1:0] : sh[DataW-1:0];
        a_q   <= {a_q[DataW-2:0], 1'b0};
      end
      default: res_q <= res_q;
    endcase
  end

  assign res_o  = res_q;
  assign done_o = done_q;
  assign busy_o = (mode_q != AU_IDLE);

endmodule

@@ hdl/rcbd_datapath.sv @@
`timescale 1ns / 1ps

module rcbd_datapath #(
  parameter int BLOCK_BITS = rcbd_pkg::BlockBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rcbd_pkg::cmd_t             cmd_i,
  input  rcbd_pkg::key_t             key_i,
  input  logic [rcbd_pkg::DataW-1:0] cipher_block_i,
  input  logic                       plain_ready_i,
  output logic                       plain_valid_o,
  output logic [rcbd_pkg::DataW-1:0] plain_block_o,
  output rcbd_pkg::status_t          stat_o
);
  import rcbd_pkg::*;

  localparam logic [DataW-1:0] BlockMask = {DataW{1'b1}} >> (DataW - BLOCK_BITS);

  logic [DataW-1:0] c_q, acc_q, bas_q, mp_q, mq_q, t_q, u_q, out_q;
  logic [KeyW-1:0]  exp_q;
  logic             out_vld_q;

  logic [DataW-1:0] a_op, b_op, d_op, res;
  logic [DataW-1:0] p_ext, q_ext, m_cur, adj, diff;
  logic             done, busy;

  assign p_ext = {{(DataW-KeyW){1'b0}}, key_i.prime_p};
  assign q_ext = {{(DataW-KeyW){1'b0}}, key_i.prime_q};
  assign m_cur = cmd_i.sel_q ? q_ext : p_ext;

  function automatic logic [DataW-1:0] pick(input src_e s, input logic [DataW-1:0] c,
                                            input logic [DataW-1:0] acc,
                                            input logic [DataW-1:0] bas,
                                            input logic [DataW-1:0] t,
                                            input logic [DataW-1:0] u,
                                            input logic [DataW-1:0] q,
                                            input logic [DataW-1:0] iq,
                                            input logic [DataW-1:0] sum);
    logic [DataW-1:0] v;
    case (s)
      SRC_C:   v = c;
      SRC_ACC: v = acc;
      SRC_BAS: v = bas;
      SRC_T:   v = t;
      SRC_U:   v = u;
      SRC_Q:   v = q;
      SRC_IQ:  v = iq;
      SRC_SUM: v = sum;
      default: v = c;
    endcase
    return v;
  endfunction

  logic [DataW-1:0] iq_ext, sum;
  assign iq_ext = {{(DataW-KeyW){1'b0}}, key_i.q_inv};
  assign sum    = mq_q + t_q;

  assign a_op = pick(cmd_i.src_a, c_q, acc_q, bas_q, t_q, u_q, q_ext, iq_ext, sum);
  assign b_op = pick(cmd_i.src_b, c_q, acc_q, bas_q, t_q, u_q, q_ext, iq_ext, sum);

  always_comb begin
    unique case (cmd_i.mod_sel)
      MOD_P:   d_op = p_ext;
      MOD_Q:   d_op = q_ext;
      MOD_N:   d_op = key_i.modulus;
      default: d_op = p_ext;
    endcase
  end

  rcbd_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .op_i    (cmd_i.op),
    .a_i     (a_op),
    .b_i     (b_op),
    .d_i     (d_op),
    .res_o   (res),
    .done_o  (done),
    .busy_o  (busy)
  );

  // t holds q mod p here: smallest multiple of p at or above q
  assign adj = (t_q == '0) ? q_ext : (q_ext + p_ext - t_q);

  always_comb begin
    if (key_i.prime_p != '0 && mp_q < mq_q) begin
      diff = mp_q + adj - mq_q;
    end else begin
      diff = mp_q - mq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      c_q <= cipher_block_i & BlockMask;
    end
    if (cmd_i.init_exp) begin
      exp_q <= cmd_i.sel_q ? key_i.exp_q : key_i.exp_p;
      acc_q <= (m_cur == DataW'(1)) ? '0 : DataW'(1);
    end else if (cmd_i.shift_exp) begin
      exp_q <= exp_q >> 1;
    end
    if (cmd_i.save_m) begin
      if (cmd_i.sel_q) begin
        mq_q <= acc_q;
      end else begin
        mp_q <= acc_q;
      end
    end
    if (cmd_i.save_diff) begin
      t_q <= diff;
    end
    if (cmd_i.wr_res) begin
      case (cmd_i.dst)
        DST_ACC: acc_q <= res;
        DST_BAS: bas_q <= res;
        DST_T:   t_q   <= res;
        DST_U:   u_q   <= res;
        default: t_q   <= res;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q <= t_q & BlockMask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (plain_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign plain_valid_o = out_vld_q;
  assign plain_block_o = out_q;

  assign stat_o.arith_done = done;
  assign stat_o.arith_busy = busy;
  assign stat_o.exp_zero   = (exp_q == '0);
  assign stat_o.exp_bit0   = exp_q[0];
  assign stat_o.exp_last   = (exp_q[KeyW-1:1] == '0);
  assign stat_o.out_free   = !out_vld_q || plain_ready_i;

endmodule

@@ hdl/rcbd_ctrl.sv @@
`timescale 1ns / 1ps

module rcbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rcbd_pkg::status_t   stat_i,
  output rcbd_pkg::cmd_t      cmd_o
);
  import rcbd_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        phase_q, phase_d;   // 0: exponent mod p, 1: exponent mod q
  mod_e        mod_ph;

  assign mod_ph = phase_q ? MOD_Q : MOD_P;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.op      = OP_REM;
    cmd_o.src_a   = SRC_T;
    cmd_o.src_b   = SRC_T;
    cmd_o.mod_sel = mod_ph;
    cmd_o.dst     = DST_T;
    cmd_o.sel_q   = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          phase_d       = 1'b0;
          state_d       = ST_PH_INIT;
        end
      end
      ST_PH_INIT: begin
        cmd_o.init_exp = 1'b1;
        cmd_o.start    = 1'b1;
        cmd_o.src_a    = SRC_C;
        state_d        = ST_BASE_W;
      end
      ST_BASE_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          cmd_o.dst    = DST_BAS;
          state_d      = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (stat_i.exp_zero) begin
          cmd_o.save_m = 1'b1;
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = ST_PH_INIT;
          end else begin
            state_d = ST_QMOD_S;
          end
        end else if (stat_i.exp_bit0) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_MUL;
          cmd_o.src_a = SRC_ACC;
          cmd_o.src_b = SRC_BAS;
          state_d     = ST_AMUL_W;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_MUL;
          cmd_o.src_a = SRC_BAS;
          cmd_o.src_b = SRC_BAS;
          state_d     = ST_BMUL_W;
        end
      end
      ST_AMUL_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_ARED_S;
        end
      end
      ST_ARED_S: begin
        cmd_o.start = 1'b1;
        state_d     = ST_ARED_W;
      end
      ST_ARED_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          cmd_o.dst    = DST_ACC;
          // no squaring after the top exponent bit
          if (stat_i.exp_last) begin
            cmd_o.shift_exp = 1'b1;
            state_d         = ST_EXP_CHK;
          end else begin
            state_d = ST_BSQ_S;
          end
        end
      end
      ST_BSQ_S: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_BAS;
        cmd_o.src_b = SRC_BAS;
        state_d     = ST_BMUL_W;
      end
      ST_BMUL_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_BRED_S;
        end
      end
      ST_BRED_S: begin
        cmd_o.start = 1'b1;
        state_d     = ST_BRED_W;
      end
      ST_BRED_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res    = 1'b1;
          cmd_o.dst       = DST_BAS;
          cmd_o.shift_exp = 1'b1;
          state_d         = ST_EXP_CHK;
        end
      end
      ST_QMOD_S: begin
        cmd_o.start   = 1'b1;
        cmd_o.src_a   = SRC_Q;
        cmd_o.mod_sel = MOD_P;
        state_d       = ST_QMOD_W;
      end
      ST_QMOD_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.save_diff = 1'b1;
        state_d         = ST_HRD_S;
      end
      ST_HRD_S: begin
        cmd_o.start   = 1'b1;
        cmd_o.mod_sel = MOD_P;
        state_d       = ST_HRD_W;
      end
      ST_HRD_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_HIQ_S;
        end
      end
      ST_HIQ_S: begin
        cmd_o.start   = 1'b1;
        cmd_o.src_a   = SRC_IQ;
        cmd_o.mod_sel = MOD_P;
        state_d       = ST_HIQ_W;
      end
      ST_HIQ_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          cmd_o.dst    = DST_U;
          state_d      = ST_HMUL_S;
        end
      end
      ST_HMUL_S: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_MUL;
        cmd_o.src_b = SRC_U;
        state_d     = ST_HMUL_W;
      end
      ST_HMUL_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_HRED_S;
        end
      end
      ST_HRED_S: begin
        cmd_o.start   = 1'b1;
        cmd_o.mod_sel = MOD_P;
        state_d       = ST_HRED_W;
      end
      ST_HRED_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_RQ_S;
        end
      end
      ST_RQ_S: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_MUL;
        cmd_o.src_b = SRC_Q;
        state_d     = ST_RQ_W;
      end
      ST_RQ_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_FIN_S;
        end
      end
      ST_FIN_S: begin
        cmd_o.start   = 1'b1;
        cmd_o.src_a   = SRC_SUM;
        cmd_o.mod_sel = MOD_N;
        state_d       = ST_FIN_W;
      end
      ST_FIN_W: begin
        if (stat_i.arith_done) begin
          cmd_o.wr_res = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/rsa_crt_block_decrypt.sv @@
// every modular product goes through the shared arithmetic unit, whose
// remainder step handles one dividend bit a cycle
// one block in flight; a finished block waits in the output register while
// the next one is taken
// reset: key registers go to p = q = 2, n = 1, exponents and inverse 0
`timescale 1ns / 1ps

module rsa_crt_block_decrypt #(
  parameter int BLOCK_BITS = rcbd_pkg::BlockBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcbd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rcbd_pkg::DataW-1:0]   cfg_data_i,
  rcbd_cipher_if.sink                  cipher_i,
  rcbd_plain_if.source                 plain_o
);
  import rcbd_pkg::*;

  key_t    key_q;
  cmd_t    cmd;
  status_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.prime_p <= KeyW'(2);
      key_q.prime_q <= KeyW'(2);
      key_q.exp_p   <= '0;
      key_q.exp_q   <= '0;
      key_q.q_inv   <= '0;
      key_q.modulus <= DataW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PRIME_P: key_q.prime_p <= cfg_data_i[KeyW-1:0];
        CFG_PRIME_Q: key_q.prime_q <= cfg_data_i[KeyW-1:0];
        CFG_EXP_P:   key_q.exp_p   <= cfg_data_i[KeyW-1:0];
        CFG_EXP_Q:   key_q.exp_q   <= cfg_data_i[KeyW-1:0];
        CFG_Q_INV:   key_q.q_inv   <= cfg_data_i[KeyW-1:0];
        CFG_MODULUS: key_q.modulus <= cfg_data_i;
        default:     key_q         <= key_q;
      endcase
    end
  end

  rcbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cipher_i.valid),
    .in_ready_o (cipher_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rcbd_datapath #(
    .BLOCK_BITS (BLOCK_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .key_i          (key_q),
    .cipher_block_i (cipher_i.cipher_block),
    .plain_ready_i  (plain_o.ready),
    .plain_valid_o  (plain_o.valid),
    .plain_block_o  (plain_o.plain_block),
    .stat_o         (stat)
  );

`ifndef SYNTHESIS
  // arithmetic unit is only started when free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !stat.arith_busy)
    else $error("arith unit started while busy");

  // completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.arith_done |=> !stat.arith_done)
    else $error("arith done held high");

  // a block just taken cannot have its result out in the following cycle
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cipher_i.valid && cipher_i.ready) |=> !$rose(plain_o.valid))
    else $error("result presented too early");
`endif

endmodule
